[rtl/core/kvtp_pkg.sv]
// Shared types, character codes and classification helpers for the key:value parser.
package kvtp_pkg;

   localparam int unsigned KEY_SLOTS  = 16;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned HALF_BYTES = 8;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef enum logic [1:0] {
      NUM_NONE = 2'd0,
      NUM_RUN  = 2'd1,
      NUM_DONE = 2'd2
   } num_phase_type;

   typedef enum logic [1:0] {
      SIGN_NONE  = 2'd0,
      SIGN_PLUS  = 2'd1,
      SIGN_MINUS = 2'd2
   } sign_type;

   typedef struct packed {
      logic                 in_value;
      logic [COUNT_W-1:0]   count;
      logic                 started;
      logic                 trail;
      logic                 invalid;
      num_phase_type        phase;
      sign_type             prev_sign;
      logic                 negative;
      logic [VALUE_W-1:0]   acc;
   } token_state_type;

   localparam token_state_type TOKEN_CLEAR = '{
      in_value:  1'b0,
      count:     '0,
      started:   1'b0,
      trail:     1'b0,
      invalid:   1'b0,
      phase:     NUM_NONE,
      prev_sign: SIGN_NONE,
      negative:  1'b0,
      acc:       '0
   };

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

endpackage

[rtl/core/key_value_telemetry_parser.sv]
// Streaming key:value telemetry parser, one byte per beat, one pair per token.
//
// Accepts one byte of a text line per clock, with req_line_end on the last
// byte, and emits one beat per comma-separated token of the form key:value
// whose key is valid (2 to MAX_KEY_CHARS characters, letter first, then
// letters, digits, '_' or '/', outer blanks trimmed) and whose value part has
// a digit run. The pair of a token appears on the rsp_ channel the cycle after
// the closing byte (comma or line end) is accepted. The parser state is a
// single register updated by a short per-byte step, so a byte is taken every
// cycle; the one-entry result register lets the next byte in while it is
// empty or its result is taken; req_ready drops only when it is full and not taken.
module key_value_telemetry_parser #(
   parameter int unsigned MAX_KEY_CHARS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_byte,
   input  logic               req_line_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_key_first_half,
   output logic [63:0]        rsp_key_second_half,
   output logic [4:0]         rsp_key_length,
   output logic signed [31:0] rsp_number_value,
   output logic               rsp_ends_line
);

   kvtp_pkg::token_state_type tok_ff, tok_in, tok_step;
   logic [7:0]  key_store_ff [kvtp_pkg::KEY_SLOTS];
   logic [7:0]  key_view     [kvtp_pkg::KEY_SLOTS];
   logic        key_write;
   logic        accept;
   logic        is_comma;
   logic        close_tok;
   logic        emit;
   logic [63:0] first_half, second_half;
   logic [31:0] value_out;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_first_ff, rsp_second_ff;
   logic [4:0]         rsp_length_ff;
   logic [31:0]        rsp_value_ff;
   logic               rsp_ends_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_comma  = (req_char_byte == kvtp_pkg::CHAR_COMMA);
   assign close_tok = is_comma || req_line_end;

   // One parser step for the current byte; a comma leaves the state as is
   // and only closes the token.
   always_comb begin
      tok_step  = tok_ff;
      key_write = 1'b0;
      if (!is_comma) begin
         if (!tok_ff.in_value) begin
            if (req_char_byte == kvtp_pkg::CHAR_COLON) begin
               tok_step.in_value  = 1'b1;
               tok_step.prev_sign = kvtp_pkg::SIGN_NONE;
            end else if (kvtp_pkg::is_blank(req_char_byte)) begin
               if (tok_ff.started) begin
                  tok_step.trail = 1'b1;
               end
            end else begin
               if (tok_ff.trail) begin
                  tok_step.invalid = 1'b1;
               end
               if (!tok_ff.started) begin
                  tok_step.started = 1'b1;
                  if (!kvtp_pkg::is_letter(req_char_byte)) begin
                     tok_step.invalid = 1'b1;
                  end
               end else if (!(kvtp_pkg::is_letter(req_char_byte) ||
                              kvtp_pkg::is_digit(req_char_byte) ||
                              req_char_byte == kvtp_pkg::CHAR_UNDER ||
                              req_char_byte == kvtp_pkg::CHAR_SLASH)) begin
                  tok_step.invalid = 1'b1;
               end
               if (tok_ff.count < kvtp_pkg::COUNT_W'(MAX_KEY_CHARS)) begin
                  key_write      = 1'b1;
                  tok_step.count = tok_ff.count + 1'b1;
               end else begin
                  tok_step.invalid = 1'b1;
               end
            end
         end else begin
            case (tok_ff.phase)
               kvtp_pkg::NUM_DONE: begin
               end
               kvtp_pkg::NUM_NONE, kvtp_pkg::NUM_RUN: begin
                  if (kvtp_pkg::is_digit(req_char_byte)) begin
                     tok_step.phase     = kvtp_pkg::NUM_RUN;
                     tok_step.prev_sign = kvtp_pkg::SIGN_NONE;
                     if (tok_ff.phase == kvtp_pkg::NUM_NONE) begin
                        tok_step.negative = (tok_ff.prev_sign == kvtp_pkg::SIGN_MINUS);
                        tok_step.acc      = {28'd0, req_char_byte[3:0]};
                     end else begin
                        tok_step.acc = (tok_ff.acc << 3) + (tok_ff.acc << 1)
                                     + {28'd0, req_char_byte[3:0]};
                     end
                  end else if (tok_ff.phase == kvtp_pkg::NUM_RUN) begin
                     tok_step.phase = kvtp_pkg::NUM_DONE;
                  end else if (req_char_byte == kvtp_pkg::CHAR_PLUS) begin
                     tok_step.prev_sign = kvtp_pkg::SIGN_PLUS;
                  end else if (req_char_byte == kvtp_pkg::CHAR_MINUS) begin
                     tok_step.prev_sign = kvtp_pkg::SIGN_MINUS;
                  end else begin
                     tok_step.prev_sign = kvtp_pkg::SIGN_NONE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign tok_in = !accept ? tok_ff : (close_tok ? kvtp_pkg::TOKEN_CLEAR : tok_step);

   // Key view with this byte's write folded in, so a line end that also ends
   // the key still sees its last character. Slots past the count read zero.
   always_comb begin
      for (int i = 0; i < kvtp_pkg::KEY_SLOTS; i++) begin
         if (kvtp_pkg::COUNT_W'(i) >= tok_step.count) begin
            key_view[i] = 8'h00;
         end else if (key_write && tok_ff.count[3:0] == 4'(i)) begin
            key_view[i] = req_char_byte;
         end else begin
            key_view[i] = key_store_ff[i];
         end
      end
      for (int i = 0; i < kvtp_pkg::HALF_BYTES; i++) begin
         first_half[63-8*i -: 8]  = key_view[i];
         second_half[63-8*i -: 8] = key_view[i+kvtp_pkg::HALF_BYTES];
      end
   end

   assign emit = close_tok && tok_step.in_value && (tok_step.phase != kvtp_pkg::NUM_NONE)
               && !tok_step.invalid && (tok_step.count >= 5'd2)
               && (tok_step.count <= kvtp_pkg::COUNT_W'(MAX_KEY_CHARS));

   assign value_out = tok_step.negative ? (32'd0 - tok_step.acc) : tok_step.acc;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff       <= kvtp_pkg::TOKEN_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         tok_ff       <= tok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && key_write) begin
         key_store_ff[tok_ff.count[3:0]] <= req_char_byte;
      end
      if (accept && emit) begin
         rsp_first_ff  <= first_half;
         rsp_second_ff <= second_half;
         rsp_length_ff <= tok_step.count;
         rsp_value_ff  <= value_out;
         rsp_ends_ff   <= req_line_end;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_key_first_half  = rsp_first_ff;
   assign rsp_key_second_half = rsp_second_ff;
   assign rsp_key_length      = rsp_length_ff;
   assign rsp_number_value    = $signed(rsp_value_ff);
   assign rsp_ends_line       = rsp_ends_ff;

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_length_ff >= 5'd2 &&
                        rsp_length_ff <= kvtp_pkg::COUNT_W'(MAX_KEY_CHARS)))
      else $error("result key length out of range");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      tok_ff.count <= kvtp_pkg::COUNT_W'(MAX_KEY_CHARS))
      else $error("key count beyond limit");

   a_line_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_line_end) |=> (tok_ff.count == '0 && !tok_ff.in_value))
      else $error("token state not cleared after line end");

   a_acc_idle: assert property (@(posedge clock) disable iff (reset)
      (tok_ff.phase == kvtp_pkg::NUM_NONE) |-> (tok_ff.acc == '0))
      else $error("accumulator nonzero before any digit");

endmodule
